/* rtl/core/key_value_table_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the key/value table unit.
// Each macro expects clk and arst_n to be visible in the module that uses it.
// ----------------------------------------------------------------------------
`ifndef KEY_VALUE_TABLE_UNIT_DEFINES_SVH
`define KEY_VALUE_TABLE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KVT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KVT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/kvt_pkg.sv */
// ----------------------------------------------------------------------------
// kvt_pkg
// Sizes, operation codes and beat types shared by the key/value table unit.
// ----------------------------------------------------------------------------
package kvt_pkg;

	localparam int unsigned DEPTH       = 256;
	localparam int unsigned KEY_WIDTH   = 64;
	localparam int unsigned VALUE_WIDTH = 64;

	// Fixed widths of the request, result and config fields.
	localparam int unsigned FIELD_W = 64;
	localparam int unsigned POS_W   = 8;
	localparam int unsigned CAP_W   = 9;

	localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	typedef enum logic [2:0] {
		MODE_INSERT   = 3'd0,
		MODE_UPDATE   = 3'd1,
		MODE_UPSERT   = 3'd2,
		MODE_ERASE    = 3'd3,
		MODE_CONTAINS = 3'd4,
		MODE_GET_KEY  = 3'd5,
		MODE_GET_POS  = 3'd6,
		MODE_UNUSED   = 3'd7
	} mode_t;

	typedef struct packed {
		mode_t              mode;
		logic [FIELD_W-1:0] req_key;
		logic [FIELD_W-1:0] req_value;
		logic [POS_W-1:0]   position;
	} req_t;

	typedef struct packed {
		logic               ok;
		logic [FIELD_W-1:0] out_key;
		logic [FIELD_W-1:0] out_value;
		logic [CNT_W-1:0]   entry_count_out;
		logic               is_empty;
	} rsp_t;

	// Access commands from the sequencer to the key and value memories.
	typedef struct packed {
		logic                   rd_en;
		logic [IDX_W-1:0]       rd_addr;
		logic                   key_we;
		logic                   val_we;
		logic [IDX_W-1:0]       wr_addr;
		logic [KEY_WIDTH-1:0]   wr_key;
		logic [VALUE_WIDTH-1:0] wr_val;
	} mem_cmd_t;

endpackage

/* rtl/core/kvt_ram.sv */
// ----------------------------------------------------------------------------
// kvt_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module kvt_ram #(
	parameter int unsigned WIDTH  = 64,
	parameter int unsigned DEPTH  = 256,
	parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* rtl/core/kvt_ctrl.sv */
// ----------------------------------------------------------------------------
// kvt_ctrl
// Request sequencer: scans the key memory or reads a slot by position, then
// updates the memories and the entry count, and builds the result beat.
// ----------------------------------------------------------------------------
`include "key_value_table_unit_defines.svh"

module kvt_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  kvt_pkg::req_t                       req,
	output logic                                done,
	output kvt_pkg::rsp_t                       rsp,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [kvt_pkg::CAP_W-1:0]           cfg_data,
	output kvt_pkg::mem_cmd_t                   mem_cmd,
	input  logic [kvt_pkg::KEY_WIDTH-1:0]       key_rdata,
	input  logic [kvt_pkg::VALUE_WIDTH-1:0]     val_rdata
);

	localparam int unsigned IW = kvt_pkg::IDX_W;
	localparam int unsigned CW = kvt_pkg::CNT_W;
	localparam int unsigned MW = kvt_pkg::CMP_W;
	localparam int unsigned FW = kvt_pkg::FIELD_W;
	localparam int unsigned KW = kvt_pkg::KEY_WIDTH;
	localparam int unsigned VW = kvt_pkg::VALUE_WIDTH;
	localparam int unsigned PW = kvt_pkg::POS_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_ERASE_RD,
		S_ERASE_WR,
		S_POS_RD,
		S_POS_WAIT
	} state_t;

	state_t                      state_q;
	logic [CW-1:0]               count_q;
	logic [kvt_pkg::CAP_W-1:0]   cap_q;
	logic [CW-1:0]               idx_q;
	logic                        valid_s1;
	logic                        done_q;
	kvt_pkg::rsp_t               rsp_q;

	kvt_pkg::mode_t              mode_q;
	logic [KW-1:0]               key_q;
	logic [VW-1:0]               val_q;
	logic [PW-1:0]               pos_q;
	logic [IW-1:0]               addr_s1;
	logic [IW-1:0]               slot_q;

	logic                        accept;
	logic [MW-1:0]               cap_ext;
	logic [MW-1:0]               cap_eff;
	logic                        full;
	logic                        match;
	logic                        scan_end;
	logic                        issue;
	logic                        pos_in;
	logic                        is_add;
	logic [IW-1:0]               count_idx;
	logic [IW-1:0]               last_idx;

	logic                        fin;
	logic                        ok_n;
	logic [FW-1:0]               okey_n;
	logic [FW-1:0]               oval_n;
	logic [CW-1:0]               cnt_n;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = !busy;
	assign done      = done_q;
	assign rsp       = rsp_q;

	// A capacity above the memory depth is clamped to the depth.
	assign cap_ext   = MW'(cap_q);
	assign cap_eff   = (cap_ext > MW'(kvt_pkg::DEPTH)) ? MW'(kvt_pkg::DEPTH) : cap_ext;
	assign full      = (MW'(count_q) >= cap_eff);

	// The read issued last cycle is compared now; the scan ends on a hit or
	// once every stored slot has been compared.
	assign match     = valid_s1 && (key_rdata == key_q);
	assign scan_end  = !match && (idx_q == count_q);
	assign issue     = (state_q == S_SCAN) && !match && (idx_q != count_q);
	assign pos_in    = (MW'(pos_q) < MW'(count_q));
	assign is_add    = (mode_q == kvt_pkg::MODE_INSERT) || (mode_q == kvt_pkg::MODE_UPSERT);
	assign count_idx = count_q[IW-1:0];
	assign last_idx  = IW'(count_q - CW'(1));

	always_comb begin
		mem_cmd         = '0;
		mem_cmd.rd_en   = issue || (state_q == S_ERASE_RD) || ((state_q == S_POS_RD) && pos_in);
		mem_cmd.rd_addr = idx_q[IW-1:0];
		if (state_q == S_ERASE_RD) begin
			mem_cmd.rd_addr = last_idx;
		end else if (state_q == S_POS_RD) begin
			mem_cmd.rd_addr = IW'(pos_q);
		end
		if (state_q == S_SCAN) begin
			if (match) begin
				if ((mode_q == kvt_pkg::MODE_UPDATE) || (mode_q == kvt_pkg::MODE_UPSERT)) begin
					mem_cmd.val_we  = 1'b1;
					mem_cmd.wr_addr = addr_s1;
					mem_cmd.wr_val  = val_q;
				end
			end else if (scan_end && is_add && !full) begin
				mem_cmd.key_we  = 1'b1;
				mem_cmd.val_we  = 1'b1;
				mem_cmd.wr_addr = count_idx;
				mem_cmd.wr_key  = key_q;
				mem_cmd.wr_val  = val_q;
			end
		end else if (state_q == S_ERASE_WR) begin
			// The last entry moves into the freed slot.
			mem_cmd.key_we  = 1'b1;
			mem_cmd.val_we  = 1'b1;
			mem_cmd.wr_addr = slot_q;
			mem_cmd.wr_key  = key_rdata;
			mem_cmd.wr_val  = val_rdata;
		end
	end

	always_comb begin
		fin    = 1'b0;
		ok_n   = 1'b0;
		okey_n = '0;
		oval_n = '0;
		cnt_n  = count_q;
		unique case (state_q)
			S_IDLE: begin
				fin = accept && (req.mode == kvt_pkg::MODE_UNUSED);
			end
			S_SCAN: begin
				if (match) begin
					unique case (mode_q)
						kvt_pkg::MODE_ERASE: begin
							fin = 1'b0;
						end
						kvt_pkg::MODE_INSERT: begin
							fin = 1'b1;
						end
						kvt_pkg::MODE_GET_KEY: begin
							fin    = 1'b1;
							ok_n   = 1'b1;
							oval_n = FW'(val_rdata);
						end
						default: begin
							fin  = 1'b1;
							ok_n = 1'b1;
						end
					endcase
				end else if (scan_end) begin
					fin = 1'b1;
					if (is_add && !full) begin
						ok_n  = 1'b1;
						cnt_n = count_q + CW'(1);
					end
				end
			end
			S_ERASE_RD: begin
				fin = 1'b0;
			end
			S_ERASE_WR: begin
				fin   = 1'b1;
				ok_n  = 1'b1;
				cnt_n = count_q - CW'(1);
			end
			S_POS_RD: begin
				fin = !pos_in;
			end
			S_POS_WAIT: begin
				fin    = 1'b1;
				ok_n   = 1'b1;
				okey_n = FW'(key_rdata);
				oval_n = FW'(val_rdata);
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			cap_q    <= kvt_pkg::CAP_W'(kvt_pkg::DEPTH);
			idx_q    <= '0;
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
			rsp_q    <= '0;
		end else begin
			done_q   <= fin;
			count_q  <= cnt_n;
			valid_s1 <= issue;
			if (fin) begin
				rsp_q.ok              <= ok_n;
				rsp_q.out_key         <= okey_n;
				rsp_q.out_value       <= oval_n;
				rsp_q.entry_count_out <= cnt_n;
				rsp_q.is_empty        <= (cnt_n == '0);
			end
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (issue) begin
				idx_q <= idx_q + CW'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (accept) begin
						if (req.mode == kvt_pkg::MODE_GET_POS) begin
							state_q <= S_POS_RD;
						end else if (req.mode != kvt_pkg::MODE_UNUSED) begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (match && (mode_q == kvt_pkg::MODE_ERASE)) begin
						state_q <= S_ERASE_RD;
					end else if (fin) begin
						state_q <= S_IDLE;
					end
				end
				S_ERASE_RD: begin
					state_q <= S_ERASE_WR;
				end
				S_ERASE_WR: begin
					state_q <= S_IDLE;
				end
				S_POS_RD: begin
					state_q <= pos_in ? S_POS_WAIT : S_IDLE;
				end
				S_POS_WAIT: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= req.mode;
			key_q  <= req.req_key[KW-1:0];
			val_q  <= req.req_value[VW-1:0];
			pos_q  <= req.position;
		end
		if (issue) begin
			addr_s1 <= idx_q[IW-1:0];
		end
		if (match) begin
			slot_q <= addr_s1;
		end
	end

	`KVT_ASSERT_SAME(a_write_not_idle, mem_cmd.key_we || mem_cmd.val_we, state_q != S_IDLE,
		"memory write while the sequencer is idle")
	`KVT_ASSERT_SAME(a_count_with_done, !$stable(count_q), done_q,
		"entry count changed without a result beat")
	`KVT_ASSERT_SAME(a_count_step, done_q, (count_q == $past(count_q)) ||
		(count_q == $past(count_q) + CW'(1)) || (count_q + CW'(1) == $past(count_q)),
		"entry count moved by more than one")
	`KVT_ASSERT_SAME(a_scan_in_range, (state_q == S_SCAN) && mem_cmd.rd_en,
		CW'(mem_cmd.rd_addr) < count_q, "scan read beyond the stored entries")
	`KVT_ASSERT_NEXT(a_start_busy, start && !busy && (req.mode != kvt_pkg::MODE_UNUSED), busy,
		"accepted request did not start the sequencer")

endmodule

/* rtl/core/key_value_table_unit.sv */
// ----------------------------------------------------------------------------
// key_value_table_unit
// Fixed-capacity key/value table held as a packed, unsorted array in two
// synchronous memories, searched linearly one slot per cycle.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake              Beat
//   -------   --------------------   -------------------------------------
//   request   start & !busy          req  (mode, req_key, req_value, position)
//   result    done, one-cycle strobe rsp  (ok, out_key, out_value, count, empty)
//   config    cfg_valid & cfg_ready  cfg_data (capacity limit)
//
// A lookup-based request reads one stored key per cycle until a hit or until
// every stored entry is compared; erase then reads the last entry and moves it
// into the freed slot. Get-by-position reads the slot at the position if it is
// stored; an unused mode reads nothing. The key memory's single read port sets
// this rate. busy drops with the done strobe, so the next request may start in
// the strobe cycle. After reset the table is empty and the capacity limit is
// the memory depth; the result strobe cannot be stalled.
//
module key_value_table_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  kvt_pkg::req_t                 req,
	output logic                          done,
	output kvt_pkg::rsp_t                 rsp,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [kvt_pkg::CAP_W-1:0]     cfg_data
);

	kvt_pkg::mem_cmd_t                    mem_cmd;
	logic [kvt_pkg::KEY_WIDTH-1:0]        key_rdata;
	logic [kvt_pkg::VALUE_WIDTH-1:0]      val_rdata;

	kvt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.mem_cmd   (mem_cmd),
		.key_rdata (key_rdata),
		.val_rdata (val_rdata)
	);

	kvt_ram #(
		.WIDTH  (kvt_pkg::KEY_WIDTH),
		.DEPTH  (kvt_pkg::DEPTH),
		.ADDR_W (kvt_pkg::IDX_W)
	) u_key_ram (
		.clk     (clk),
		.rd_en   (mem_cmd.rd_en),
		.rd_addr (mem_cmd.rd_addr),
		.rd_data (key_rdata),
		.wr_en   (mem_cmd.key_we),
		.wr_addr (mem_cmd.wr_addr),
		.wr_data (mem_cmd.wr_key)
	);

	kvt_ram #(
		.WIDTH  (kvt_pkg::VALUE_WIDTH),
		.DEPTH  (kvt_pkg::DEPTH),
		.ADDR_W (kvt_pkg::IDX_W)
	) u_val_ram (
		.clk     (clk),
		.rd_en   (mem_cmd.rd_en),
		.rd_addr (mem_cmd.rd_addr),
		.rd_data (val_rdata),
		.wr_en   (mem_cmd.val_we),
		.wr_addr (mem_cmd.wr_addr),
		.wr_data (mem_cmd.wr_val)
	);

endmodule
